// ----- hw/rtl/signed_int_to_decimal_ascii_defines.svh -----
// Assertion macros shared by the signed integer to decimal text converter.
`ifndef SIGNED_INT_TO_DECIMAL_ASCII_DEFINES_SVH
`define SIGNED_INT_TO_DECIMAL_ASCII_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define ITOA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define ITOA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/itoa_pkg.sv -----
// Package with the widths, character codes and control types of the converter.
`timescale 1ns / 1ps
`default_nettype none
package itoa_pkg;

  localparam int VALUE_WIDTH   = 32;
  localparam int BCD_DIGITS    = (VALUE_WIDTH * 30103) / 100000 + 1;
  localparam int BCD_WIDTH     = 4 * BCD_DIGITS;
  localparam int BIT_CNT_WIDTH = $clog2(VALUE_WIDTH + 1);
  localparam int DIG_CNT_WIDTH = $clog2(BCD_DIGITS + 1);
  localparam int CHAR_WIDTH    = 7;

  localparam logic [CHAR_WIDTH-1:0] CH_MINUS = 7'd45;
  localparam logic [CHAR_WIDTH-1:0] CH_ZERO  = 7'd48;

  typedef logic [3:0] bcd_digit_t;

  typedef struct packed {
    logic start;
    logic shift;
  } dab_ctl_t;

  typedef struct packed {
    logic       busy;
    bcd_digit_t top;
  } dab_stat_t;

endpackage
`default_nettype wire

// ----- hw/rtl/itoa_if.sv -----
// Valid/ready channel interfaces for the input value and the output characters.
`timescale 1ns / 1ps
`default_nettype none
interface itoa_in_if import itoa_pkg::*; ();
  logic                          valid;
  logic                          ready;
  logic signed [VALUE_WIDTH-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink (input valid, input value, output ready);
endinterface

interface itoa_out_if import itoa_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CHAR_WIDTH-1:0] character;
  logic                  last;

  modport source (output valid, output character, output last, input ready);
  modport sink (input valid, input character, input last, output ready);
endinterface
`default_nettype wire

// ----- hw/rtl/itoa_dabble.sv -----
// Bit-serial binary to BCD converter with a digit shift-out for the emitter.
`timescale 1ns / 1ps
`default_nettype none
module itoa_dabble import itoa_pkg::*; (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire dab_ctl_t               ctl,
  input  wire logic [VALUE_WIDTH-1:0] mag,
  output dab_stat_t                   stat
);

  logic [VALUE_WIDTH-1:0]   mag_r, mag_nxt;
  logic [BCD_WIDTH-1:0]     bcd_r, bcd_nxt;
  logic [BCD_WIDTH-1:0]     adj;
  logic [BIT_CNT_WIDTH-1:0] cnt_r, cnt_nxt;

  always_comb begin
    adj = bcd_r;
    for (int i = 0; i < BCD_DIGITS; i++) begin
      if (bcd_r[4*i +: 4] >= 4'd5) begin
        adj[4*i +: 4] = bcd_r[4*i +: 4] + 4'd3;
      end
    end
  end

  always_comb begin
    mag_nxt = mag_r;
    bcd_nxt = bcd_r;
    cnt_nxt = cnt_r;
    priority if (ctl.start) begin
      mag_nxt = mag;
      bcd_nxt = '0;
      cnt_nxt = BIT_CNT_WIDTH'(VALUE_WIDTH);
    end else if (cnt_r != '0) begin
      mag_nxt = {mag_r[VALUE_WIDTH-2:0], 1'b0};
      bcd_nxt = {adj[BCD_WIDTH-2:0], mag_r[VALUE_WIDTH-1]};
      cnt_nxt = cnt_r - BIT_CNT_WIDTH'(1);
    end else if (ctl.shift) begin
      bcd_nxt = {bcd_r[BCD_WIDTH-5:0], 4'b0000};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mag_r <= mag_nxt;
    bcd_r <= bcd_nxt;
  end

  assign stat.busy = (cnt_r != '0);
  assign stat.top  = bcd_r[BCD_WIDTH-1 -: 4];

endmodule
`default_nettype wire

// ----- hw/rtl/signed_int_to_decimal_ascii.sv -----
// Top level of the signed integer to decimal ASCII text converter.
// One signed value is taken per beat on the input channel and its decimal text
// leaves on the output channel one character per beat, most significant digit
// first, with a leading minus sign for negative values and the last flag on
// the final digit. An item is accepted in ST_IDLE and its magnitude passes bit
// by bit through the bit-serial binary to BCD shift register in ST_CONV; then
// ST_SIGN loads the minus sign of a negative value and ST_EMIT steps through
// the BCD_DIGITS (10) digits, one per cycle while the output is not stalled,
// dropping leading zeros. No new value is taken until the last digit is loaded.
// The output register lets the next value enter while the final character
// still waits to be taken.
`timescale 1ns / 1ps
`default_nettype none
`include "signed_int_to_decimal_ascii_defines.svh"
module signed_int_to_decimal_ascii import itoa_pkg::*; (
  input wire logic   clk,
  input wire logic   rst_n,
  itoa_in_if.sink    in_ch,
  itoa_out_if.source out_ch
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_CONV = 2'd1;
  localparam logic [1:0] ST_SIGN = 2'd2;
  localparam logic [1:0] ST_EMIT = 2'd3;

  logic [1:0]               state_r, state_nxt;
  logic                     neg_r, neg_nxt;
  logic                     started_r, started_nxt;
  logic [DIG_CNT_WIDTH-1:0] dig_cnt_r, dig_cnt_nxt;
  logic                     out_valid_r, out_valid_nxt;
  logic [CHAR_WIDTH-1:0]    out_char_r;
  logic                     out_last_r;

  logic                     load;
  logic [CHAR_WIDTH-1:0]    ld_char;
  logic                     ld_last;
  logic                     slot_free;
  logic                     is_last;
  logic [VALUE_WIDTH-1:0]   raw;
  logic [VALUE_WIDTH-1:0]   mag;
  dab_ctl_t                 ctl;
  dab_stat_t                stat;

  assign raw       = in_ch.value;
  assign mag       = raw[VALUE_WIDTH-1] ? (~raw + VALUE_WIDTH'(1)) : raw;
  assign slot_free = !out_valid_r || out_ch.ready;
  assign is_last   = (dig_cnt_r == DIG_CNT_WIDTH'(1));

  itoa_dabble u_dabble (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (ctl),
    .mag   (mag),
    .stat  (stat)
  );

  always_comb begin
    state_nxt   = state_r;
    neg_nxt     = neg_r;
    started_nxt = started_r;
    dig_cnt_nxt = dig_cnt_r;
    ctl         = '0;
    load        = 1'b0;
    ld_char     = CH_ZERO;
    ld_last     = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_ch.valid) begin
          ctl.start = 1'b1;
          neg_nxt   = raw[VALUE_WIDTH-1];
          state_nxt = ST_CONV;
        end
      end
      ST_CONV: begin
        if (!stat.busy) begin
          dig_cnt_nxt = DIG_CNT_WIDTH'(BCD_DIGITS);
          started_nxt = 1'b0;
          state_nxt   = neg_r ? ST_SIGN : ST_EMIT;
        end
      end
      ST_SIGN: begin
        if (slot_free) begin
          load      = 1'b1;
          ld_char   = CH_MINUS;
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        priority if (!started_r && stat.top == 4'd0 && !is_last) begin
          ctl.shift   = 1'b1;
          dig_cnt_nxt = dig_cnt_r - DIG_CNT_WIDTH'(1);
        end else if (slot_free) begin
          load        = 1'b1;
          ld_char     = CH_ZERO + {3'b000, stat.top};
          ld_last     = is_last;
          ctl.shift   = 1'b1;
          dig_cnt_nxt = dig_cnt_r - DIG_CNT_WIDTH'(1);
          started_nxt = 1'b1;
          if (is_last) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign out_valid_nxt = load ? 1'b1 : (out_ch.ready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      started_r   <= 1'b0;
      dig_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      started_r   <= started_nxt;
      dig_cnt_r   <= dig_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    neg_r <= neg_nxt;
    if (load) begin
      out_char_r <= ld_char;
      out_last_r <= ld_last;
    end
  end

  assign in_ch.ready      = (state_r == ST_IDLE);
  assign out_ch.valid     = out_valid_r;
  assign out_ch.character = out_char_r;
  assign out_ch.last      = out_last_r;

  `ITOA_ASSERT_NOW(a_idle_not_busy, state_r == ST_IDLE, !stat.busy, "Converter busy while idle.")
  `ITOA_ASSERT_NEXT(a_accept_converts, in_ch.valid && in_ch.ready, state_r == ST_CONV && stat.busy, "Accepted beat did not start a conversion.")
  `ITOA_ASSERT_NOW(a_sign_not_last, out_valid_r && out_char_r == CH_MINUS, !out_last_r, "Minus sign flagged as last.")
  `ITOA_ASSERT_NOW(a_emit_count, state_r == ST_EMIT, dig_cnt_r != '0, "Digit count ran out during emission.")

endmodule
`default_nettype wire
